@@ rtl/cqe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cqe_pkg;

    localparam int OPCODE_W = 3;
    localparam int CAP_W    = 7;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ   = 3'd0,
        OP_DEQ   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_DUMP  = 3'd3,
        OP_SIZE  = 3'd4,
        OP_EMPTY = 3'd5,
        OP_FULL  = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        INFO_NONE,
        INFO_SIZE,
        INFO_EMPTY,
        INFO_FULL
    } info_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      push;        // write the incoming word at the tail
        logic      pop;         // advance the head, drop one word
        logic      walk_start;  // read at head, walk from there
        logic      walk_next;   // step the walk and read the next slot
        logic      load_rd;     // load the result from the read data
        logic      rd_last;     // last flag to go with load_rd
        logic      load_info;   // load a result with no stored word
        info_sel_t info;
        logic      fail;
    } cqe_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic walk_last;
        logic out_last;
    } cqe_sts_t;

endpackage

`default_nettype wire

@@ rtl/cqe_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cqe_cmd_if
    import cqe_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic        [OPCODE_W-1:0]   opcode;
    logic signed [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

`default_nettype wire

@@ rtl/cqe_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cqe_rsp_if
    import cqe_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] data_out;
    logic        [COUNT_W-1:0]    count_or_flag;
    logic                         status;
    logic                         last;

    modport source (output valid, output data_out, output count_or_flag,
                    output status, output last, input ready);
    modport sink   (input valid, input data_out, input count_or_flag,
                    input status, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/cqe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cqe_ctrl
    import cqe_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire logic [OPCODE_W-1:0] cmd_opcode,
    output logic                     cmd_ready,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    input  wire cqe_sts_t            sts,
    output cqe_ctl_t                 ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_OUT
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    opcode_t op_reg;
    opcode_t op_next;
    opcode_t op_in;

    assign op_in     = opcode_t'(cmd_opcode);
    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

    always_comb
    begin
        ctl        = '0;
        ctl.info   = INFO_NONE;
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next = op_in;
                    case (op_in)
                        OP_ENQ:
                        begin
                            ctl.load_info = 1'b1;
                            ctl.fail      = sts.full;
                            ctl.push      = !sts.full;
                            state_next    = S_OUT;
                        end
                        OP_DEQ, OP_PEEK:
                        begin
                            if (sts.empty)
                            begin
                                ctl.load_info = 1'b1;
                                ctl.fail      = 1'b1;
                                state_next    = S_OUT;
                            end
                            else
                            begin
                                ctl.walk_start = 1'b1;
                                state_next     = S_RD;
                            end
                        end
                        OP_DUMP:
                        begin
                            // an empty queue dumps nothing
                            if (!sts.empty)
                            begin
                                ctl.walk_start = 1'b1;
                                state_next     = S_RD;
                            end
                        end
                        OP_SIZE:
                        begin
                            ctl.load_info = 1'b1;
                            ctl.info      = INFO_SIZE;
                            state_next    = S_OUT;
                        end
                        OP_EMPTY:
                        begin
                            ctl.load_info = 1'b1;
                            ctl.info      = INFO_EMPTY;
                            state_next    = S_OUT;
                        end
                        OP_FULL:
                        begin
                            ctl.load_info = 1'b1;
                            ctl.info      = INFO_FULL;
                            state_next    = S_OUT;
                        end
                        default:
                        begin
                            // undefined opcode: drop it
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                ctl.load_rd = 1'b1;
                ctl.rd_last = (op_reg == OP_DUMP) ? sts.walk_last : 1'b1;
                ctl.pop     = (op_reg == OP_DEQ);
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    if (op_reg == OP_DUMP && !sts.out_last)
                    begin
                        ctl.walk_next = 1'b1;
                        state_next    = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ENQ;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cqe_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cqe_datapath
    import cqe_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic        [CAP_W-1:0]      cfg_wdata,
    input  wire logic signed [DATA_WIDTH-1:0] push_value,
    input  wire cqe_ctl_t                     ctl,
    output cqe_sts_t                          sts,
    output logic signed      [DATA_WIDTH-1:0] data_out,
    output logic             [COUNT_W-1:0]    count_or_flag,
    output logic                              status,
    output logic                              last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] rdata_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] walk_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic [CNT_W-1:0] rem_reg;
    logic             rd_en;
    logic             full;
    logic             empty;

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic        [COUNT_W-1:0]    count_reg;
    logic                         status_reg;
    logic                         last_reg;

    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(idx) + CNT_W'(1);
        if (n >= cap)
            return '0;
        return n[IDX_W-1:0];
    endfunction

    // clamp the written capacity to 1..DEPTH
    always_comb
    begin
        if (cfg_wdata == '0)
            cap_next = CNT_W'(1);
        else if (cfg_wdata > CAP_W'(DEPTH))
            cap_next = CNT_W'(DEPTH);
        else
            cap_next = cfg_wdata[CNT_W-1:0];
    end

    assign full  = (occ_reg >= cap_reg);
    assign empty = (occ_reg == '0);
    assign rd_en = ctl.walk_start || ctl.walk_next;
    assign rd_addr = ctl.walk_start ? head_reg : step_idx(walk_reg, cap_reg);

    assign sts.empty     = empty;
    assign sts.full      = full;
    assign sts.walk_last = (rem_reg == CNT_W'(1));
    assign sts.out_last  = last_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[tail_reg] <= push_value;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            cap_reg  <= CNT_W'(DEPTH);
            walk_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cfg_we)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            cap_reg  <= cap_next;
        end
        else
        begin
            if (ctl.push)
            begin
                tail_reg <= step_idx(tail_reg, cap_reg);
                occ_reg  <= occ_reg + CNT_W'(1);
            end
            if (ctl.pop)
            begin
                head_reg <= step_idx(head_reg, cap_reg);
                occ_reg  <= occ_reg - CNT_W'(1);
            end
            if (ctl.walk_start)
            begin
                walk_reg <= head_reg;
                rem_reg  <= occ_reg;
            end
            else if (ctl.walk_next)
            begin
                walk_reg <= rd_addr;
                rem_reg  <= rem_reg - CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.load_rd)
        begin
            data_reg   <= rdata_reg;
            count_reg  <= '0;
            status_reg <= 1'b0;
            last_reg   <= ctl.rd_last;
        end
        else if (ctl.load_info)
        begin
            data_reg   <= '0;
            status_reg <= ctl.fail;
            last_reg   <= 1'b1;
            case (ctl.info)
                INFO_SIZE:  count_reg <= COUNT_W'(occ_reg);
                INFO_EMPTY: count_reg <= COUNT_W'(empty);
                INFO_FULL:  count_reg <= COUNT_W'(full);
                default:    count_reg <= '0;
            endcase
        end
    end

    assign data_out      = data_reg;
    assign count_or_flag = count_reg;
    assign status        = status_reg;
    assign last          = last_reg;

    a_occ_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= cap_reg)
        else $error("occupancy above capacity");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !full)
        else $error("write into a full queue");

    a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> !empty)
        else $error("pop from an empty queue");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.walk_next |-> (rem_reg > CNT_W'(1)))
        else $error("dump walked past the rear");

endmodule

`default_nettype wire

@@ rtl/circular_queue_engine.sv @@
// Circular FIFO of signed words with opcodes for enqueue, dequeue, peek,
// dump, size, empty and full.
// Channels: cmd carries opcode and push_value; rsp returns data_out,
// count_or_flag, status and last. A word moves on a channel at a rising
// edge where valid and ready are both high. cfg_we/cfg_wdata write the
// capacity (0 acts as 1, above DEPTH acts as DEPTH) and empty the queue;
// write it only while no command is in flight.
// Sequencing: one command at a time. Enqueue, failures and queries give
// their word in the cycle after acceptance; dequeue and peek first read
// the slot memory through its registered read port, then load the word.
// cmd takes a new word the cycle after the result leaves. Dump gives one
// word per stored entry through the same read port, reading each next
// entry once the word before it is taken, with last on the rear entry;
// an empty queue dumps nothing and the next command is taken at once.
// Opcode 7 is dropped without a result.
// Reset: head, tail and occupancy clear, capacity goes to DEPTH; the slot
// memory is not cleared. A stalled receiver holds the result word and
// the controller, and cmd stays not ready until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module circular_queue_engine
    import cqe_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    cqe_cmd_if.sink               cmd,
    cqe_rsp_if.source             rsp
);

    cqe_ctl_t ctl;
    cqe_sts_t sts;

    // sequencing: accept, read the slot memory, hold the result word
    cqe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_opcode (cmd.opcode),
        .cmd_ready  (cmd.ready),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    // slot memory, pointers, occupancy and the result register
    cqe_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .push_value    (cmd.push_value),
        .ctl           (ctl),
        .sts           (sts),
        .data_out      (rsp.data_out),
        .count_or_flag (rsp.count_or_flag),
        .status        (rsp.status),
        .last          (rsp.last)
    );

endmodule

`default_nettype wire
